// ----- rtl/lrc_pkg.sv -----
`default_nettype none

package lrc_pkg;

  localparam int unsigned MAX_ENTRIES      = 256;
  localparam int unsigned MAX_FIELD_DIGITS = 3;

  localparam int unsigned ENTRY_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned FDC_W   = $clog2(MAX_FIELD_DIGITS + 1);
  localparam int unsigned ACC_W   = 10;
  localparam int unsigned TIME_W  = 26;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned STAT_W  = 2;

  // event queue between the parser and the time unit
  localparam int unsigned EVQ_DEPTH = 4;
  localparam int unsigned EVQ_PTR_W = $clog2(EVQ_DEPTH);
  localparam int unsigned EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

  typedef struct packed {
    logic       new_file;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [IDX_W-1:0]  entry_index;
    logic [STAT_W-1:0] status;
  } result_t;

  // one closed tag, as classified by the parser
  typedef struct packed {
    logic [ACC_W-1:0]  minute;
    logic [ACC_W-1:0]  second;
    logic [ACC_W-1:0]  fraction;
    logic [FDC_W-1:0]  frac_digits;
    logic [IDX_W-1:0]  entry_index;
    logic [STAT_W-1:0] status;
  } tag_event_t;

endpackage

`default_nettype wire

// ----- rtl/lrc_time_tag_parser_unit.sv -----
// lyric time tag parser
// input channel: one text byte per word on item_i, taken when push is high and
// full is low. item_i.new_file clears the entry count and parse state before the
// byte is used. output channel: one word per closed tag on result_o, valid while
// empty is low, taken when pop is high.
// a result word holds the tag time in ms, its table index and a status
// (ok, malformed, table full); dropped tags carry zero time and index.
// throughput: one byte per cycle while full is low. bytes that close no tag give no word.
// path: the tag event of a closing bracket goes from the parser through the event
// queue and the multiply stage to the output register, which drives result_o.
// stalls: the parser pushes tag events into a four-deep queue; when pop stays
// low the output register and multiply stage hold, the queue fills and full
// rises, so no word is lost. ordinary text bytes are taken as long as the queue
// is not full.
// reset: asynchronous, active low; empties all stages and clears the entry count.
`default_nettype none

module lrc_time_tag_parser_unit import lrc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item_i,
  output logic          empty,
  input  wire logic     pop,
  output result_t       result_o
);

  logic       accept;
  logic       ev_push;
  tag_event_t ev_in, ev_out;
  logic       q_empty, q_full;
  logic       ev_take;
  logic       res_valid;

  assign full   = q_full;
  assign accept = push && !q_full;

  lrc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .ev_push_o (ev_push),
    .ev_o      (ev_in)
  );

  lrc_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .pop_i   (ev_take),
    .data_o  (ev_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ev_valid_i     (!q_empty),
    .ev_i           (ev_out),
    .ev_take_o      (ev_take),
    .result_o       (result_o),
    .result_valid_o (res_valid),
    .result_take_i  (pop)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

// ----- rtl/lrc_front.sv -----
`default_nettype none

module lrc_front import lrc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire in_item_t   item_i,
  output logic            ev_push_o,
  output tag_event_t      ev_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_OPEN,
    PH_MIN,
    PH_SEC,
    PH_FRAC,
    PH_BAD
  } phase_e;

  phase_e             phase_q, phase_d, phase_c;
  logic [ACC_W-1:0]   min_q, min_d, min_c;
  logic [ACC_W-1:0]   sec_q, sec_d, sec_c;
  logic [ACC_W-1:0]   frac_q, frac_d, frac_c;
  logic [FDC_W-1:0]   fdc_q, fdc_d, fdc_c;
  logic [ENTRY_W-1:0] cnt_q, cnt_d, cnt_c;
  logic [ACC_W-1:0]   acc_sel, acc_next;
  logic               dig;
  logic [3:0]         digit;
  logic [7:0]         b;

  assign b     = item_i.byte_in;
  assign dig   = (b >= CH_ZERO) && (b <= CH_NINE);
  // low nibble of an ascii digit is its value
  assign digit = b[3:0];

  always_comb begin
    // new file clears the parse state before the word is looked at
    phase_c = item_i.new_file ? PH_IDLE : phase_q;
    min_c   = item_i.new_file ? '0 : min_q;
    sec_c   = item_i.new_file ? '0 : sec_q;
    frac_c  = item_i.new_file ? '0 : frac_q;
    fdc_c   = item_i.new_file ? '0 : fdc_q;
    cnt_c   = item_i.new_file ? '0 : cnt_q;

    case (phase_c)
      PH_MIN:  acc_sel = min_c;
      PH_SEC:  acc_sel = sec_c;
      default: acc_sel = frac_c;
    endcase
    acc_next = ACC_W'({acc_sel, 3'b000} + {acc_sel, 1'b0} + {{(ACC_W - 1){1'b0}}, digit});

    phase_d   = phase_c;
    min_d     = min_c;
    sec_d     = sec_c;
    frac_d    = frac_c;
    fdc_d     = fdc_c;
    cnt_d     = cnt_c;
    ev_push_o = 1'b0;
    ev_o      = '0;

    case (phase_c)
      PH_IDLE: begin
        if (b == CH_LBRACK) phase_d = PH_OPEN;
      end
      PH_OPEN: begin
        if (dig) begin
          min_d   = {{(ACC_W - 4){1'b0}}, digit};
          sec_d   = '0;
          frac_d  = '0;
          fdc_d   = FDC_W'(1);
          phase_d = PH_MIN;
        end else if (b != CH_LBRACK) begin
          phase_d = PH_IDLE;
        end
      end
      PH_MIN, PH_SEC, PH_FRAC: begin
        if (dig) begin
          if (fdc_c >= FDC_W'(MAX_FIELD_DIGITS)) begin
            phase_d = PH_BAD;
          end else begin
            fdc_d = fdc_c + FDC_W'(1);
            case (phase_c)
              PH_MIN:  min_d  = acc_next;
              PH_SEC:  sec_d  = acc_next;
              default: frac_d = acc_next;
            endcase
          end
        end else if (b == CH_RBRACK) begin
          ev_push_o = 1'b1;
          if (phase_c == PH_MIN) begin
            ev_o.status = ST_MALFORMED;
          end else if (cnt_c >= ENTRY_W'(MAX_ENTRIES)) begin
            ev_o.status = ST_FULL;
          end else begin
            ev_o.status      = ST_OK;
            ev_o.minute      = min_c;
            ev_o.second      = sec_c;
            ev_o.fraction    = frac_c;
            ev_o.frac_digits = (phase_c == PH_FRAC) ? fdc_c : '0;
            ev_o.entry_index = IDX_W'(cnt_c);
            cnt_d            = cnt_c + ENTRY_W'(1);
          end
          phase_d = PH_IDLE;
          min_d   = '0;
          sec_d   = '0;
          frac_d  = '0;
          fdc_d   = '0;
        end else if (phase_c == PH_MIN && b == CH_COLON) begin
          phase_d = PH_SEC;
          fdc_d   = '0;
        end else if (phase_c == PH_SEC && b == CH_DOT) begin
          phase_d = PH_FRAC;
          fdc_d   = '0;
        end else begin
          phase_d = PH_BAD;
        end
      end
      default: begin
        if (b == CH_RBRACK) begin
          ev_push_o   = 1'b1;
          ev_o.status = ST_MALFORMED;
          phase_d     = PH_IDLE;
          min_d       = '0;
          sec_d       = '0;
          frac_d      = '0;
          fdc_d       = '0;
        end else begin
          phase_d = PH_BAD;
        end
      end
    endcase

    if (!accept_i) ev_push_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      min_q   <= '0;
      sec_q   <= '0;
      frac_q  <= '0;
      fdc_q   <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      frac_q  <= frac_d;
      fdc_q   <= fdc_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ENTRY_W'(MAX_ENTRIES))
    else $error("entry count past table size");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_push_o && ev_o.status != ST_OK |->
      ev_o.minute == '0 && ev_o.second == '0 && ev_o.fraction == '0 &&
      ev_o.entry_index == '0)
    else $error("dropped tag carries a time");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !item_i.new_file && !(ev_push_o && ev_o.status == ST_OK) |=>
      cnt_q == $past(cnt_q))
    else $error("entry count moved without a tag");

endmodule

`default_nettype wire

// ----- rtl/lrc_evq.sv -----
`default_nettype none

module lrc_evq import lrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire tag_event_t  data_i,
  input  wire logic        pop_i,
  output tag_event_t       data_o,
  output logic             empty_o,
  output logic             full_o
);

  tag_event_t           mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [EVQ_CNT_W-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == EVQ_CNT_W'(EVQ_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + EVQ_PTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + EVQ_PTR_W'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + EVQ_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - EVQ_CNT_W'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= EVQ_CNT_W'(EVQ_DEPTH))
    else $error("event queue count overflow");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("event pushed into full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EVQ_PTR_W'(cnt_q) == EVQ_PTR_W'(wr_ptr_q - rd_ptr_q))
    else $error("event queue pointers out of step with count");

endmodule

`default_nettype wire

// ----- rtl/lrc_back.sv -----
`default_nettype none

module lrc_back import lrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        ev_valid_i,
  input  wire tag_event_t  ev_i,
  output logic             ev_take_o,
  output result_t          result_o,
  output logic             result_valid_o,
  input  wire logic        result_take_i
);

  typedef struct packed {
    logic [TIME_W-1:0] min_ms;
    logic [19:0]       sec_ms;
    logic [16:0]       frac_ms;
    logic [IDX_W-1:0]  entry_index;
    logic [STAT_W-1:0] status;
  } part_t;

  part_t   s1_q, s1_d;
  logic    s1_v_q;
  result_t out_q;
  logic    out_v_q;
  logic    out_free, s1_free;

  assign out_free  = !out_v_q || result_take_i;
  assign s1_free   = !s1_v_q || out_free;
  assign ev_take_o = ev_valid_i && s1_free;

  always_comb begin
    s1_d.min_ms      = TIME_W'(ev_i.minute) * TIME_W'(MS_PER_MIN);
    s1_d.sec_ms      = 20'(ev_i.second) * 20'(MS_PER_SEC);
    // fraction scaled by how many digits it had
    case (ev_i.frac_digits)
      FDC_W'(1): s1_d.frac_ms = 17'(ev_i.fraction) * 17'd100;
      FDC_W'(2): s1_d.frac_ms = 17'(ev_i.fraction) * 17'd10;
      FDC_W'(3): s1_d.frac_ms = 17'(ev_i.fraction);
      default:   s1_d.frac_ms = '0;
    endcase
    s1_d.entry_index = ev_i.entry_index;
    s1_d.status      = ev_i.status;
  end

  always_ff @(posedge clk_i) begin
    if (ev_take_o) s1_q <= s1_d;
    if (s1_v_q && out_free) begin
      out_q.time_ms     <= s1_q.min_ms + TIME_W'(s1_q.sec_ms) + TIME_W'(s1_q.frac_ms);
      out_q.entry_index <= s1_q.entry_index;
      out_q.status      <= s1_q.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free)  s1_v_q  <= ev_take_o;
      if (out_free) out_v_q <= s1_v_q;
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_v_q;

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && out_v_q && !result_take_i |=> s1_v_q && $stable(s1_q))
    else $error("stage one lost while output stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !result_take_i |=> out_v_q && $stable(out_q))
    else $error("output word changed while stalled");

  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !out_free |-> !ev_take_o)
    else $error("event taken into a stalled stage");

endmodule

`default_nettype wire

// ----- test/lrc_time_tag_parser_unit_tb.sv -----
`default_nettype none

module lrc_time_tag_parser_unit_tb;
  import lrc_pkg::*;

  typedef enum logic [2:0] {
    TAG_IDLE, TAG_OPEN, TAG_MIN, TAG_SEC, TAG_FRAC, TAG_BAD
  } tag_phase_e;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_LEN    = 60;
  localparam int unsigned CALM_TAIL   = 80;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push   = 1'b0;
  logic     full;
  in_item_t item_i = '0;
  logic     empty;
  logic     pop    = 1'b0;
  result_t  result_o;

  lrc_time_tag_parser_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // tag tracker state
  tag_phase_e       tag_phase = TAG_IDLE;
  logic [ACC_W-1:0] minutes_acc = '0;
  logic [ACC_W-1:0] seconds_acc = '0;
  logic [ACC_W-1:0] fraction_acc = '0;
  int unsigned      field_digits = 0;
  int unsigned      fraction_digits = 0;
  int unsigned      tags_logged = 0;

  result_t     awaited_results[$];
  in_item_t    text_bytes[$];
  bit          text_taken = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned drain_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  task automatic report_mismatch(input string what);
    $display("cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic clear_tag_state();
    tag_phase       = TAG_IDLE;
    minutes_acc     = '0;
    seconds_acc     = '0;
    fraction_acc    = '0;
    field_digits    = 0;
    fraction_digits = 0;
  endtask

  // follows one accepted byte and queues the word it closes, if any
  task automatic track_byte(input in_item_t w);
    logic [7:0]  b;
    bit          numeral;
    bit          closes_bad;
    bit          closes_good;
    int unsigned d;
    int unsigned frac_ms;
    int unsigned total_ms;
    result_t     r;
    b           = w.byte_in;
    numeral     = (b >= CH_ZERO) && (b <= CH_NINE);
    d           = numeral ? int'(b - CH_ZERO) : 0;
    closes_bad  = 1'b0;
    closes_good = 1'b0;
    if (w.new_file) begin
      clear_tag_state();
      tags_logged = 0;
    end
    case (tag_phase)
      TAG_IDLE: begin
        if (b == CH_LBRACK) tag_phase = TAG_OPEN;
      end
      TAG_OPEN: begin
        if (numeral) begin
          clear_tag_state();
          minutes_acc  = ACC_W'(d);
          field_digits = 1;
          tag_phase    = TAG_MIN;
        end else if (b != CH_LBRACK) begin
          tag_phase = TAG_IDLE;
        end
      end
      TAG_MIN, TAG_SEC, TAG_FRAC: begin
        if (numeral) begin
          if (field_digits >= MAX_FIELD_DIGITS) begin
            tag_phase = TAG_BAD;
          end else begin
            case (tag_phase)
              TAG_MIN: minutes_acc  = ACC_W'(minutes_acc * 10 + d);
              TAG_SEC: seconds_acc  = ACC_W'(seconds_acc * 10 + d);
              default: fraction_acc = ACC_W'(fraction_acc * 10 + d);
            endcase
            field_digits++;
          end
        end else if (b == CH_RBRACK) begin
          // a closing bracket straight after the minutes means no colon
          if (tag_phase == TAG_MIN) closes_bad = 1'b1;
          else closes_good = 1'b1;
        end else if (tag_phase == TAG_MIN && b == CH_COLON) begin
          tag_phase    = TAG_SEC;
          field_digits = 0;
        end else if (tag_phase == TAG_SEC && b == CH_DOT) begin
          tag_phase    = TAG_FRAC;
          field_digits = 0;
        end else begin
          tag_phase = TAG_BAD;
        end
      end
      default: begin
        if (b == CH_RBRACK) closes_bad = 1'b1;
      end
    endcase
    r = '0;
    if (closes_bad) begin
      r.status = ST_MALFORMED;
      awaited_results.push_back(r);
      clear_tag_state();
    end
    if (closes_good) begin
      if (tag_phase == TAG_FRAC) fraction_digits = field_digits;
      case (fraction_digits)
        1:       frac_ms = fraction_acc * 100;
        2:       frac_ms = fraction_acc * 10;
        3:       frac_ms = fraction_acc;
        default: frac_ms = 0;
      endcase
      total_ms = minutes_acc * 60000 + seconds_acc * 1000 + frac_ms;
      if (tags_logged >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        r.time_ms     = TIME_W'(total_ms);
        r.entry_index = IDX_W'(tags_logged);
        r.status      = ST_OK;
        tags_logged++;
      end
      awaited_results.push_back(r);
      clear_tag_state();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit fresh);
    in_item_t w;
    w.new_file = fresh;
    w.byte_in  = b;
    text_bytes.push_back(w);
  endtask

  task automatic queue_text(input string s, input bit fresh);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], fresh && (i == 0));
  endtask

  task automatic queue_digits(input int unsigned n);
    repeat (n) queue_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  // lyric text between tags, now and then raw bytes of any value
  task automatic queue_lyric(input bit fresh);
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) queue_byte(8'($urandom_range(0, 255)), fresh && (i == 0));
      else queue_byte(8'($urandom_range(32, 126)), fresh && (i == 0));
    end
  endtask

  // a time tag, well formed when tidy, otherwise with one random flaw
  task automatic queue_tag(input bit tidy);
    int unsigned flaw;
    flaw = tidy ? 0 : $urandom_range(1, 7);
    queue_byte(CH_LBRACK, 1'b0);
    if ($urandom_range(0, 9) == 0) queue_byte(CH_LBRACK, 1'b0);
    if (flaw == 6) begin
      queue_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      return;
    end
    queue_digits(flaw == 2 ? 4 : $urandom_range(1, 3));
    if (flaw == 1) begin
      queue_byte(CH_RBRACK, 1'b0);
      return;
    end
    queue_byte(CH_COLON, 1'b0);
    queue_digits($urandom_range(0, 3));
    if (flaw == 3) queue_byte(8'($urandom_range(0, 255)), 1'b0);
    if (flaw == 7) queue_byte(8'h0A, 1'b0);
    if (flaw == 4 || flaw == 5 || $urandom_range(0, 1) == 1) begin
      queue_byte(CH_DOT, 1'b0);
      queue_digits(flaw == 5 ? 4 : $urandom_range(0, 3));
      if (flaw == 4) queue_byte($urandom_range(0, 1) ? CH_DOT : CH_COLON, 1'b0);
    end
    queue_byte(CH_RBRACK, 1'b0);
  endtask

  // bytes drawn mostly from the tag alphabet, with random file restarts
  task automatic queue_noise();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(4, 12);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       b = CH_LBRACK;
        1:       b = CH_RBRACK;
        2:       b = $urandom_range(0, 1) ? CH_COLON : CH_DOT;
        3:       b = CH_ZERO + 8'($urandom_range(0, 9));
        default: b = 8'($urandom_range(0, 255));
      endcase
      queue_byte(b, $urandom_range(0, 15) == 0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lrc_time_tag_parser_unit_tb: errors");
      $finish;
    end
  end

  // monitor: inputs taken and words out, both sampled at the rising edge
  always @(posedge clk_i) begin
    result_t want;
    text_taken <= rst_ni && push && !full;
    if (rst_ni) begin
      if (push && !full) begin
        track_byte(item_i);
        bytes_taken++;
      end
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("word with none awaited: time %0d index %0d status %0d",
                                    result_o.time_ms, result_o.entry_index, result_o.status));
        end else begin
          want = awaited_results.pop_front();
          if (result_o.time_ms !== want.time_ms)
            report_mismatch($sformatf("time_ms %0d, want %0d", result_o.time_ms, want.time_ms));
          if (result_o.entry_index !== want.entry_index)
            report_mismatch($sformatf("entry_index %0d, want %0d",
                                      result_o.entry_index, want.entry_index));
          if (result_o.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", result_o.status, want.status));
        end
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    bit offer;
    if (text_taken) void'(text_bytes.pop_front());
    if (!rst_ni) begin
      offer = 1'b0;
    end else if (push && !text_taken) begin
      offer = 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      offer = 1'b0;
    end else if (text_bytes.size() == 0) begin
      offer = 1'b0;
    end else if (text_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 6);
      offer    = 1'b0;
    end else begin
      offer = 1'b1;
    end
    push <= offer;
    if (offer) item_i <= text_bytes[0];
  end

  // receiver, with one long hold-off while the run of short tags streams in
  always @(negedge clk_i) begin
    bit take;
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      take      = 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap--;
      take = 1'b0;
    end else if (text_bytes.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      drain_gap = $urandom_range(0, 6);
      take      = 1'b0;
    end else begin
      take = 1'b1;
    end
    pop <= take;
  end

  initial begin
    // largest fields, doubled bracket with empty seconds and fraction,
    // bracket without a digit, tag without a colon
    queue_text("[999:999.999]", 1'b1);
    queue_text("[[0:.]", 1'b0);
    queue_text("[a]", 1'b0);
    queue_text("[7]", 1'b0);

    // a run of short tags, dense enough to fill the block while the receiver holds off
    queue_byte(8'h0A, 1'b1);
    repeat (40) begin
      queue_byte(CH_LBRACK, 1'b0);
      queue_digits(1);
      queue_byte(CH_COLON, 1'b0);
      queue_digits($urandom_range(0, 1));
      queue_byte(CH_RBRACK, 1'b0);
    end
    repeat (4) queue_tag(1'b0);

    repeat (12) begin
      queue_lyric($urandom_range(0, 19) == 0);
      queue_tag($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) queue_noise();
    end
    queue_byte(8'h0A, 1'b0);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_bytes.size() != 0 || push) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("lrc_time_tag_parser_unit_tb: clean");
    end else begin
      $display("lrc_time_tag_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
